// ===== sv/iff_pkg.sv =====
// Shared types and constants for the integer field formatter.
// Used by iff_digit_unit and integer_field_formatter_top; depends on nothing.
`default_nettype none

package iff_pkg;

    localparam int MAX_FIELD_WIDTH = 62;
    localparam int WIDTH_W         = 6;
    localparam int VALUE_W         = 64;
    localparam int BCD_DIGITS      = 20;
    localparam int WORK_W          = 4 * BCD_DIGITS;
    localparam int DIGIT_SLOTS     = 24;
    localparam int DIGIT_IDX_W     = 5;
    localparam int SEG_COUNT       = 7;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_X_LOWER = 8'h78;
    localparam logic [7:0] CHAR_X_UPPER = 8'h58;
    localparam logic [7:0] LOWER_OFFSET = 8'h20;
    localparam logic [7:0] ALPHA_GAP    = 8'd7;

    // Output segments in emission order.
    localparam int SEG_PFX0       = 0;
    localparam int SEG_PFX1       = 1;
    localparam int SEG_SPACE_LEAD = 2;
    localparam int SEG_SIGN       = 3;
    localparam int SEG_ZERO_PAD   = 4;
    localparam int SEG_DIGITS     = 5;
    localparam int SEG_SPACE_TAIL = 6;

    typedef enum logic [2:0] {
        OP_SDEC = 3'd0,
        OP_UDEC = 3'd1,
        OP_OCT  = 3'd2,
        OP_HEXL = 3'd3,
        OP_HEXU = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        DM_DEC,
        DM_OCT,
        DM_HEX
    } dig_mode_t;

    typedef struct packed {
        logic      start;
        dig_mode_t mode;
        logic      narrow;
    } dig_req_t;

    typedef struct packed {
        logic                   done;
        logic [DIGIT_IDX_W-1:0] count;
    } dig_sts_t;

endpackage

`default_nettype wire

// ===== sv/iff_digit_unit.sv =====
// Digit extraction unit: for decimal, shift-and-add-3 binary to BCD
// conversion; then a shifting split into digits, least significant first,
// into a small store. Depends on iff_pkg.
`default_nettype none

module iff_digit_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  iff_pkg::dig_req_t              req,
    input  logic [iff_pkg::VALUE_W-1:0]    magnitude,
    input  logic [iff_pkg::DIGIT_IDX_W-1:0] rd_idx,
    output iff_pkg::dig_sts_t              sts,
    output logic [3:0]                     rd_digit
);
    import iff_pkg::*;

    typedef enum logic [1:0] {
        DG_IDLE,
        DG_DABBLE,
        DG_SPLIT
    } dg_state_t;

    dg_state_t              state_reg;
    dig_mode_t              mode_reg;
    logic [VALUE_W-1:0]     bin_reg;
    logic [WORK_W-1:0]      work_reg;
    logic [5:0]             iter_reg;
    logic [DIGIT_IDX_W-1:0] nd_reg;
    logic [3:0]             store_reg [DIGIT_SLOTS];

    logic [WORK_W-1:0]      adj;
    logic [WORK_W-1:0]      work_next;
    logic [3:0]             split_digit;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (work_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = work_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = work_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        if (mode_reg == DM_OCT)
        begin
            work_next   = work_reg >> 3;
            split_digit = {1'b0, work_reg[2:0]};
        end
        else
        begin
            work_next   = work_reg >> 4;
            split_digit = work_reg[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DG_IDLE;
            nd_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                DG_IDLE:
                begin
                    if (req.start)
                    begin
                        mode_reg <= req.mode;
                        nd_reg   <= '0;
                        if (req.narrow)
                        begin
                            bin_reg  <= {magnitude[31:0], 32'd0};
                            iter_reg <= 6'd31;
                        end
                        else
                        begin
                            bin_reg  <= magnitude;
                            iter_reg <= 6'd63;
                        end
                        if (req.mode == DM_DEC)
                        begin
                            work_reg  <= '0;
                            state_reg <= DG_DABBLE;
                        end
                        else
                        begin
                            work_reg  <= {{(WORK_W-VALUE_W){1'b0}}, magnitude};
                            state_reg <= DG_SPLIT;
                        end
                    end
                end
                DG_DABBLE:
                begin
                    work_reg <= {adj[WORK_W-2:0], bin_reg[VALUE_W-1]};
                    bin_reg  <= {bin_reg[VALUE_W-2:0], 1'b0};
                    iter_reg <= iter_reg - 6'd1;
                    if (iter_reg == 6'd0)
                    begin
                        state_reg <= DG_SPLIT;
                    end
                end
                DG_SPLIT:
                begin
                    store_reg[nd_reg] <= split_digit;
                    nd_reg            <= nd_reg + 1'b1;
                    work_reg          <= work_next;
                    if (work_next == '0)
                    begin
                        state_reg <= DG_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= DG_IDLE;
                end
            endcase
        end
    end

    assign sts.done  = (state_reg == DG_IDLE);
    assign sts.count = nd_reg;

    always_comb
    begin
        if (rd_idx < DIGIT_IDX_W'(DIGIT_SLOTS))
        begin
            rd_digit = store_reg[rd_idx];
        end
        else
        begin
            rd_digit = '0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/integer_field_formatter_top.sv =====
// Top level of the integer field formatter: input capture, character sequencer
// and output register. Depends on iff_pkg and iff_digit_unit.
//
// One transaction in carries an integer and a decoded printf-style spec; the
// block answers with the formatted ASCII text, one character per output
// transaction, with tlast on the final one. The input is accepted only while
// the block is idle. Digit extraction produces one digit per cycle, preceded for
// decimal by binary to BCD conversion of 32 (narrow) or 64 (wide) bits in
// the shift-and-add unit; the characters then leave at one per cycle through
// the output register while m_axis_tready does not hold them back. Items with
// an unused operation code are accepted and produce no output.
`default_nettype none

module integer_field_formatter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // value[63:0], left_justify[64], zero_pad[65], alternate[66],
    // field_width[72:67], zeros above
    input  logic [79:0] s_axis_tdata,
    // operation[2:0], wide[3]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_char[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);
    import iff_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_WAIT,
        T_EMIT
    } top_state_t;

    top_state_t           state_reg;
    op_t                  op_reg;
    logic                 left_reg;
    logic                 zpad_reg;
    logic                 alt_reg;
    logic                 minus_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [SEG_COUNT-1:0] seg_reg;
    logic [WIDTH_W-1:0]   count_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic [2:0]           in_op;
    logic                 in_wide;
    logic [VALUE_W-1:0]   in_value;
    logic [WIDTH_W-1:0]   in_width;
    logic [VALUE_W-1:0]   ext_value;
    logic                 in_minus;
    logic [VALUE_W-1:0]   magnitude;
    dig_req_t             dig_req;
    dig_sts_t             dig_sts;
    logic [3:0]           rd_digit;
    logic [DIGIT_IDX_W-1:0] rd_idx;

    logic [WIDTH_W-1:0]   len;
    logic [WIDTH_W-1:0]   pad;
    logic [SEG_COUNT-1:0] seg_mask;
    logic [SEG_COUNT-1:0] first_seg;
    logic [SEG_COUNT-1:0] above;
    logic [SEG_COUNT-1:0] seg_next;
    logic                 is_upper;
    logic                 slot_free;
    logic                 load_out;
    logic                 seg_done;
    logic                 char_last;
    logic [7:0]           digit_char;
    logic [7:0]           char_next;

    function automatic logic [WIDTH_W-1:0] seg_count(
        input logic [SEG_COUNT-1:0] seg,
        input logic [WIDTH_W-1:0]   pad_len,
        input logic [DIGIT_IDX_W-1:0] nd
    );
        logic [WIDTH_W-1:0] cnt;
        begin
            if (seg[SEG_SPACE_LEAD] || seg[SEG_ZERO_PAD] || seg[SEG_SPACE_TAIL])
            begin
                cnt = pad_len;
            end
            else if (seg[SEG_DIGITS])
            begin
                cnt = {1'b0, nd};
            end
            else
            begin
                cnt = WIDTH_W'(1);
            end
            return cnt;
        end
    endfunction

    assign in_value = s_axis_tdata[63:0];
    assign in_width = s_axis_tdata[72:67];
    assign in_op    = s_axis_tuser[2:0];
    assign in_wide  = s_axis_tuser[3];

    assign s_axis_tready = (state_reg == T_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (in_wide)
        begin
            ext_value = in_value;
        end
        else if (in_op == OP_SDEC)
        begin
            ext_value = {{32{in_value[31]}}, in_value[31:0]};
        end
        else
        begin
            ext_value = {32'd0, in_value[31:0]};
        end
        in_minus  = (in_op == OP_SDEC) && ext_value[VALUE_W-1];
        magnitude = in_minus ? (~ext_value + 64'd1) : ext_value;
    end

    always_comb
    begin
        dig_req.start  = accept && (in_op <= OP_HEXU);
        dig_req.narrow = !in_wide;
        case (in_op)
            OP_OCT:           dig_req.mode = DM_OCT;
            OP_HEXL, OP_HEXU: dig_req.mode = DM_HEX;
            default:          dig_req.mode = DM_DEC;
        endcase
    end

    iff_digit_unit u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (dig_req),
        .magnitude (magnitude),
        .rd_idx    (rd_idx),
        .sts       (dig_sts),
        .rd_digit  (rd_digit)
    );

    assign rd_idx   = count_reg[DIGIT_IDX_W-1:0] - 1'b1;
    assign is_upper = (op_reg == OP_HEXU);

    always_comb
    begin
        len = {1'b0, dig_sts.count} + {{(WIDTH_W-1){1'b0}}, minus_reg};
        pad = (width_reg > len) ? (width_reg - len) : '0;

        seg_mask[SEG_PFX0]       = alt_reg && (op_reg == OP_OCT || op_reg == OP_HEXL ||
                                               op_reg == OP_HEXU);
        seg_mask[SEG_PFX1]       = alt_reg && (op_reg == OP_HEXL || op_reg == OP_HEXU);
        seg_mask[SEG_SPACE_LEAD] = !left_reg && !zpad_reg && (pad != '0);
        seg_mask[SEG_SIGN]       = minus_reg;
        seg_mask[SEG_ZERO_PAD]   = !left_reg && zpad_reg && (pad != '0);
        seg_mask[SEG_DIGITS]     = 1'b1;
        seg_mask[SEG_SPACE_TAIL] = left_reg && (pad != '0);

        first_seg = seg_mask & (~seg_mask + 1'b1);
        above     = seg_mask & ~(seg_reg | (seg_reg - 1'b1));
        seg_next  = above & (~above + 1'b1);
        seg_done  = (count_reg == WIDTH_W'(1));
        char_last = seg_done && (above == '0);
    end

    always_comb
    begin
        if (rd_digit < 4'd10)
        begin
            digit_char = CHAR_ZERO + {4'd0, rd_digit};
        end
        else if (is_upper)
        begin
            digit_char = CHAR_ZERO + {4'd0, rd_digit} + ALPHA_GAP;
        end
        else
        begin
            digit_char = CHAR_ZERO + {4'd0, rd_digit} + ALPHA_GAP + LOWER_OFFSET;
        end

        if (seg_reg[SEG_PFX0] || seg_reg[SEG_ZERO_PAD])
        begin
            char_next = CHAR_ZERO;
        end
        else if (seg_reg[SEG_PFX1])
        begin
            char_next = is_upper ? CHAR_X_UPPER : CHAR_X_LOWER;
        end
        else if (seg_reg[SEG_SIGN])
        begin
            char_next = CHAR_MINUS;
        end
        else if (seg_reg[SEG_DIGITS])
        begin
            char_next = digit_char;
        end
        else
        begin
            char_next = CHAR_SPACE;
        end
    end

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign load_out  = (state_reg == T_EMIT) && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
            seg_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                T_IDLE:
                begin
                    if (dig_req.start)
                    begin
                        op_reg    <= op_t'(in_op);
                        left_reg  <= s_axis_tdata[64];
                        zpad_reg  <= s_axis_tdata[65];
                        alt_reg   <= s_axis_tdata[66];
                        minus_reg <= in_minus;
                        width_reg <= (in_width > WIDTH_W'(MAX_FIELD_WIDTH)) ?
                                     WIDTH_W'(MAX_FIELD_WIDTH) : in_width;
                        state_reg <= T_WAIT;
                    end
                end
                T_WAIT:
                begin
                    if (dig_sts.done)
                    begin
                        seg_reg   <= first_seg;
                        count_reg <= seg_count(first_seg, pad, dig_sts.count);
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= char_next;
                        out_last_reg  <= char_last;
                        if (char_last)
                        begin
                            state_reg <= T_IDLE;
                        end
                        else if (seg_done)
                        begin
                            seg_reg   <= seg_next;
                            count_reg <= seg_count(seg_next, pad, dig_sts.count);
                        end
                        else
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
